@@ design/bsm_pkg.sv @@
// Package for the bank switch mapper with cycle IRQ counter.
// Holds field widths, request and target codes, register offsets and address constants.
// No dependencies.
`default_nettype none

package bsm_pkg;

	// field widths
	localparam int REQ_TYPE_W = 2;
	localparam int ADDR_W     = 16;
	localparam int DATA_W     = 8;
	localparam int TARGET_W   = 3;
	localparam int IDX_W      = 18;
	localparam int UNMAP_W    = 8;
	localparam int MIRROR_W   = 2;
	localparam int CHR_BANK_W = 8;
	localparam int PRG_BANK_W = 4;
	localparam int COUNT_W    = 16;
	localparam int VARIANT_W  = 3;
	localparam int CHR_REGS   = 8;
	localparam int CHR_SEL_W  = $clog2(CHR_REGS);
	localparam int CHR_WIN_W  = 10;
	localparam int PRG_WIN_W  = 14;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 4;
	localparam logic [CFG_INDEX_W-1:0] CFG_BOARD_VARIANT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHR_RAM       = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LAST_PRG      = 2'd2;

	// cpu-side prg ram size
	localparam int PRG_RAM_BYTES = 8192;
	localparam int PRG_RAM_AW    = $clog2(PRG_RAM_BYTES);

	// board variants
	localparam logic [VARIANT_W-1:0] VARIANT_DIRECT = 3'd4;
	localparam logic [VARIANT_W-1:0] VARIANT_LATCH  = 3'd5;

	// register bases and offsets
	localparam logic [ADDR_W-1:0] BASE_DIRECT = 16'h6000;
	localparam logic [ADDR_W-1:0] BASE_LATCH  = 16'h8000;
	localparam logic [3:0] REG_PRG    = 4'h8;
	localparam logic [3:0] REG_MIRROR = 4'h9;
	localparam logic [3:0] REG_CTRL   = 4'hA;
	localparam logic [3:0] REG_CNT_LO = 4'hB;
	localparam logic [3:0] REG_CNT_HI = 4'hC;

	// address map
	localparam logic [ADDR_W-1:0] PRG_RAM_LO   = 16'h6000;
	localparam logic [ADDR_W-1:0] PRG_RAM_HI   = 16'h7FFF;
	localparam logic [ADDR_W-1:0] PRG_ROM_LO   = 16'h8000;
	localparam logic [ADDR_W-1:0] PRG_FIXED_LO = 16'hC000;
	localparam logic [ADDR_W-1:0] CHR_TOP      = 16'h2000;
	localparam logic [UNMAP_W-1:0] UNMAPPED_CPU = 8'h00;
	localparam logic [UNMAP_W-1:0] UNMAPPED_PPU = 8'hFF;

	// reset values of configuration
	localparam logic [PRG_BANK_W-1:0] LAST_PRG_RESET = 4'hF;

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_CPU_WRITE = 2'd0,
		REQ_CPU_READ  = 2'd1,
		REQ_PPU_READ  = 2'd2,
		REQ_TICK      = 2'd3
	} req_type_t;

	typedef enum logic [TARGET_W-1:0] {
		TGT_NONE    = 3'd0,
		TGT_PRG_RAM = 3'd1,
		TGT_PRG_ROM = 3'd2,
		TGT_CHR_ROM = 3'd3,
		TGT_CHR_RAM = 3'd4
	} target_t;

endpackage

`default_nettype wire

@@ design/bsm_req_if.sv @@
// Request channel interface: valid/ready handshake with bus event payload.
// Depends on bsm_pkg.
`default_nettype none

interface bsm_req_if;
	import bsm_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [ADDR_W-1:0]     bus_addr;
	logic [DATA_W-1:0]     write_data;

	modport source (output valid, output req_type, output bus_addr, output write_data,
		input ready);
	modport sink (input valid, input req_type, input bus_addr, input write_data,
		output ready);
endinterface

`default_nettype wire

@@ design/bsm_rsp_if.sv @@
// Response channel interface: valid/ready handshake with translated access payload.
// Depends on bsm_pkg.
`default_nettype none

interface bsm_rsp_if;
	import bsm_pkg::*;

	logic                valid;
	logic                ready;
	logic [TARGET_W-1:0] target_memory;
	logic [IDX_W-1:0]    mem_index;
	logic [UNMAP_W-1:0]  unmapped_value;
	logic                irq_line;
	logic [MIRROR_W-1:0] mirror_mode;

	modport source (output valid, output target_memory, output mem_index,
		output unmapped_value, output irq_line, output mirror_mode, input ready);
	modport sink (input valid, input target_memory, input mem_index,
		input unmapped_value, input irq_line, input mirror_mode, output ready);
endinterface

`default_nettype wire

@@ design/bank_switch_mapper_irq_unit.sv @@
// Top level of the bank switch mapper with cycle IRQ counter.
// Depends on bsm_pkg, bsm_req_if and bsm_rsp_if.
`default_nettype none

// Takes one bus event per request (cpu write, cpu read, ppu pattern read or
// cpu clock tick) and returns exactly one response per request in the cycle
// after acceptance. A request is taken in every cycle, limited only by the
// single response register: while a response waits on a stalled sink the
// next request is held off. Register writes, counter ticks and address
// translation are all resolved in the accepting cycle from the current bank
// and counter state, so back-to-back ticks decrement the counter once each.
// User must write config (board variant, chr ram present, fixed last prg
// bank) on cfg_we/cfg_index/cfg_data while the block is idle; not enforced.
module bank_switch_mapper_irq_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bsm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [bsm_pkg::CFG_DATA_W-1:0]  cfg_data,
	bsm_req_if.sink                              req,
	bsm_rsp_if.source                            rsp
);
	import bsm_pkg::*;

	// configuration registers
	logic [VARIANT_W-1:0]  variant_q;
	logic                  chr_ram_q;
	logic [PRG_BANK_W-1:0] last_prg_q;

	// mapper state
	logic [CHR_BANK_W-1:0] chr_bank_q [CHR_REGS];
	logic [CHR_BANK_W-1:0] chr_bank_n [CHR_REGS];
	logic [PRG_BANK_W-1:0] prg_bank_q, prg_bank_n;
	logic [MIRROR_W-1:0]   mirror_q, mirror_n;
	logic                  count_en_q, count_en_n;
	logic [COUNT_W-1:0]    irq_count_q, irq_count_n;
	logic [COUNT_W-1:0]    irq_reload_q, irq_reload_n;
	logic                  irq_pend_q, irq_pend_n;

	// response register
	logic                 rsp_valid_q;
	target_t              target_q, target_n;
	logic [IDX_W-1:0]     index_q, index_n;
	logic [UNMAP_W-1:0]   unmap_q, unmap_n;
	logic                 irq_q;
	logic [MIRROR_W-1:0]  mirror_out_q;

	logic                 req_fire;
	logic                 var_ok;
	logic [ADDR_W-1:0]    reg_base;
	logic                 reg_hit;
	logic [3:0]           reg_off;
	logic [ADDR_W-1:0]    ram_off;
	logic [PRG_BANK_W-1:0] rom_bank;

	// handshake: a new request whenever the response slot is free or draining
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_fire  = req.valid && req.ready;

	// register decode at exact addresses
	assign var_ok   = (variant_q == VARIANT_DIRECT) || (variant_q == VARIANT_LATCH);
	assign reg_base = (variant_q == VARIANT_DIRECT) ? BASE_DIRECT : BASE_LATCH;
	assign reg_off  = req.bus_addr[3:0];
	assign reg_hit  = var_ok && (req.bus_addr[ADDR_W-1:4] == reg_base[ADDR_W-1:4])
		&& (reg_off <= REG_CNT_HI);

	assign ram_off  = req.bus_addr - PRG_RAM_LO;
	assign rom_bank = (req.bus_addr < PRG_FIXED_LO) ? prg_bank_q : last_prg_q;

	// next state and response for the request on the input
	always_comb begin
		chr_bank_n   = chr_bank_q;
		prg_bank_n   = prg_bank_q;
		mirror_n     = mirror_q;
		count_en_n   = count_en_q;
		irq_count_n  = irq_count_q;
		irq_reload_n = irq_reload_q;
		irq_pend_n   = irq_pend_q;
		target_n     = TGT_NONE;
		index_n      = '0;
		unmap_n      = UNMAPPED_CPU;

		unique case (req_type_t'(req.req_type))
			REQ_CPU_WRITE: begin
				if (reg_hit) begin
					if (!reg_off[3]) begin
						chr_bank_n[reg_off[CHR_SEL_W-1:0]] = req.write_data;
					end else begin
						unique case (reg_off)
							REG_PRG: begin
								prg_bank_n = req.write_data[PRG_BANK_W-1:0];
							end
							REG_MIRROR: begin
								mirror_n = req.write_data[MIRROR_W-1:0];
							end
							REG_CTRL: begin
								count_en_n = req.write_data[0];
								irq_pend_n = req.write_data[0] && (irq_count_q == '0);
								if (variant_q == VARIANT_LATCH) begin
									irq_count_n = irq_reload_q;
								end
							end
							REG_CNT_LO: begin
								if (variant_q == VARIANT_DIRECT) begin
									irq_count_n[7:0] = req.write_data;
								end else begin
									irq_reload_n[7:0] = req.write_data;
								end
							end
							REG_CNT_HI: begin
								if (variant_q == VARIANT_DIRECT) begin
									irq_count_n[15:8] = req.write_data;
								end else begin
									irq_reload_n[15:8] = req.write_data;
								end
							end
							default: begin
							end
						endcase
					end
				end
			end
			REQ_CPU_READ: begin
				if (req.bus_addr >= PRG_RAM_LO && req.bus_addr <= PRG_RAM_HI) begin
					target_n = TGT_PRG_RAM;
					index_n  = IDX_W'(ram_off[PRG_RAM_AW-1:0]);
				end else if (req.bus_addr >= PRG_ROM_LO) begin
					target_n = TGT_PRG_ROM;
					index_n  = {rom_bank, req.bus_addr[PRG_WIN_W-1:0]};
				end
			end
			REQ_PPU_READ: begin
				if (req.bus_addr < CHR_TOP) begin
					if (chr_ram_q) begin
						target_n = TGT_CHR_RAM;
						index_n  = IDX_W'(req.bus_addr);
					end else begin
						target_n = TGT_CHR_ROM;
						index_n  = {chr_bank_q[req.bus_addr[CHR_WIN_W+CHR_SEL_W-1:CHR_WIN_W]],
							req.bus_addr[CHR_WIN_W-1:0]};
					end
				end else begin
					unmap_n = UNMAPPED_PPU;
				end
			end
			REQ_TICK: begin
				// count down while enabled, flag the irq on zero
				if (count_en_q) begin
					if (irq_count_q == '0) begin
						irq_pend_n = 1'b1;
					end else begin
						irq_count_n = irq_count_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q  <= VARIANT_DIRECT;
			chr_ram_q  <= 1'b0;
			last_prg_q <= LAST_PRG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BOARD_VARIANT: variant_q  <= cfg_data[VARIANT_W-1:0];
				CFG_CHR_RAM:       chr_ram_q  <= cfg_data[0];
				CFG_LAST_PRG:      last_prg_q <= cfg_data[PRG_BANK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// mapper state update on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHR_REGS; i++) begin
				chr_bank_q[i] <= '0;
			end
			prg_bank_q   <= '0;
			mirror_q     <= '0;
			count_en_q   <= 1'b0;
			irq_count_q  <= '0;
			irq_reload_q <= '0;
			irq_pend_q   <= 1'b0;
		end else if (req_fire) begin
			chr_bank_q   <= chr_bank_n;
			prg_bank_q   <= prg_bank_n;
			mirror_q     <= mirror_n;
			count_en_q   <= count_en_n;
			irq_count_q  <= irq_count_n;
			irq_reload_q <= irq_reload_n;
			irq_pend_q   <= irq_pend_n;
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req.ready) begin
			rsp_valid_q <= req.valid;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			target_q     <= target_n;
			index_q      <= index_n;
			unmap_q      <= unmap_n;
			irq_q        <= irq_pend_n;
			mirror_out_q <= mirror_n;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.target_memory  = target_q;
	assign rsp.mem_index      = index_q;
	assign rsp.unmapped_value = unmap_q;
	assign rsp.irq_line       = irq_q;
	assign rsp.mirror_mode    = mirror_out_q;

endmodule

`default_nettype wire

@@ design/bsm_checker.sv @@
// Port-level checker for the bank switch mapper, bound to the top level.
// Depends on bsm_pkg and bank_switch_mapper_irq_unit.
`default_nettype none

module bsm_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           req_valid,
	input wire logic                           req_ready,
	input wire logic                           rsp_valid,
	input wire logic                           rsp_ready,
	input wire logic [bsm_pkg::TARGET_W-1:0]   target_memory,
	input wire logic [bsm_pkg::IDX_W-1:0]      mem_index,
	input wire logic [bsm_pkg::UNMAP_W-1:0]    unmapped_value
);
	import bsm_pkg::*;

	// every accepted request yields a response in the next cycle
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> rsp_valid)
		else $error("accepted request gave no response");

	// an empty response slot always takes a request
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request held off with empty response slot");

	// no target means no index
	a_none_index: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && target_memory == TGT_NONE) |-> (mem_index == '0))
		else $error("index set without a target");

	// only an unmapped ppu read shows a nonzero open-bus value
	a_unmapped: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && unmapped_value != UNMAPPED_CPU)
		|-> (target_memory == TGT_NONE && unmapped_value == UNMAPPED_PPU))
		else $error("bad unmapped value");

	// stalled response holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(mem_index)
		&& $stable(target_memory)))
		else $error("stalled response changed");

endmodule

bind bank_switch_mapper_irq_unit bsm_checker u_bsm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.target_memory  (rsp.target_memory),
	.mem_index      (rsp.mem_index),
	.unmapped_value (rsp.unmapped_value)
);

`default_nettype wire

@@ verif/bsm_tb_pkg.sv @@
// Bank mapper tracker for the testbench. It mirrors the bank, mirroring and
// counter state and predicts one response per request, checked in order.
// Depends on bsm_pkg.
package bsm_tb_pkg;
	timeunit 1ns;
	timeprecision 1ps;
	import bsm_pkg::*;

	typedef struct packed {
		logic [TARGET_W-1:0] target;
		logic [IDX_W-1:0]    mem_idx;
		logic [UNMAP_W-1:0]  idle_value;
		logic                irq;
		logic [MIRROR_W-1:0] mirror;
	} xlate_t;

	class mapper_tracker;
		// configuration copy
		logic [VARIANT_W-1:0]  variant;
		logic                  chr_ram;
		logic [PRG_BANK_W-1:0] last_bank;
		// bank and counter state
		logic [CHR_BANK_W-1:0] chr_bank [CHR_REGS];
		logic [PRG_BANK_W-1:0] prg_bank;
		logic [MIRROR_W-1:0]   mirror;
		logic                  count_en;
		logic [COUNT_W-1:0]    counter;
		logic [COUNT_W-1:0]    reload;
		logic                  irq_pend;
		xlate_t                expected_xlate [$];
		int unsigned           mismatches;

		function new();
			variant = VARIANT_DIRECT;
			chr_ram = 1'b0;
			last_bank = LAST_PRG_RESET;
			foreach (chr_bank[i]) chr_bank[i] = '0;
			prg_bank = '0;
			mirror = '0;
			count_en = 1'b0;
			counter = '0;
			reload = '0;
			irq_pend = 1'b0;
			mismatches = 0;
		endfunction

		function void configure(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
			case (index)
				CFG_BOARD_VARIANT: variant = value[VARIANT_W-1:0];
				CFG_CHR_RAM:       chr_ram = value[0];
				CFG_LAST_PRG:      last_bank = value[PRG_BANK_W-1:0];
				default: ;
			endcase
		endfunction

		// register file write, exact decode from the variant's base
		function void reg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
			logic [ADDR_W-1:0] base;
			logic [3:0]        offset;
			if (variant == VARIANT_DIRECT) base = BASE_DIRECT;
			else if (variant == VARIANT_LATCH) base = BASE_LATCH;
			else return;
			if (addr < base || addr > base + REG_CNT_HI) return;
			offset = 4'(addr - base);
			if (offset < REG_PRG) begin
				chr_bank[offset[CHR_SEL_W-1:0]] = data;
				return;
			end
			case (offset)
				REG_PRG:    prg_bank = data[PRG_BANK_W-1:0];
				REG_MIRROR: mirror = data[MIRROR_W-1:0];
				REG_CTRL: begin
					// enable, clear pending, raise at once if already at zero
					count_en = data[0];
					irq_pend = count_en && counter == '0;
					if (variant == VARIANT_LATCH) counter = reload;
				end
				REG_CNT_LO: begin
					if (variant == VARIANT_DIRECT) counter[7:0] = data;
					else reload[7:0] = data;
				end
				default: begin
					if (variant == VARIANT_DIRECT) counter[15:8] = data;
					else reload[15:8] = data;
				end
			endcase
		endfunction

		// one cpu clock of the irq counter
		function void count_tick();
			if (!count_en) return;
			if (counter == '0) irq_pend = 1'b1;
			else counter = counter - 1'b1;
		endfunction

		function void take_request(logic [REQ_TYPE_W-1:0] kind, logic [ADDR_W-1:0] addr,
				logic [DATA_W-1:0] data);
			xlate_t r;
			r = '0;
			case (kind)
				REQ_CPU_WRITE: reg_write(addr, data);
				REQ_CPU_READ: begin
					if (addr >= PRG_RAM_LO && addr <= PRG_RAM_HI) begin
						r.target = TGT_PRG_RAM;
						r.mem_idx = IDX_W'((addr - PRG_RAM_LO) % PRG_RAM_BYTES);
					end else if (addr >= PRG_ROM_LO) begin
						r.target = TGT_PRG_ROM;
						r.mem_idx = {(addr < PRG_FIXED_LO) ? prg_bank : last_bank,
							addr[PRG_WIN_W-1:0]};
					end else begin
						r.idle_value = UNMAPPED_CPU;
					end
				end
				REQ_PPU_READ: begin
					if (addr < CHR_TOP) begin
						if (chr_ram) begin
							r.target = TGT_CHR_RAM;
							r.mem_idx = IDX_W'(addr);
						end else begin
							r.target = TGT_CHR_ROM;
							r.mem_idx = {chr_bank[addr[CHR_WIN_W+CHR_SEL_W-1:CHR_WIN_W]],
								addr[CHR_WIN_W-1:0]};
						end
					end else begin
						r.idle_value = UNMAPPED_PPU;
					end
				end
				default: count_tick();
			endcase
			r.irq = irq_pend;
			r.mirror = mirror;
			expected_xlate.push_back(r);
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void compare_response(logic [TARGET_W-1:0] target, logic [IDX_W-1:0] mem_idx,
				logic [UNMAP_W-1:0] idle_value, logic irq, logic [MIRROR_W-1:0] mirror_out);
			xlate_t want;
			if (expected_xlate.size() == 0) begin
				$display("%0t: response with no request outstanding, expected none, got target %0h",
					$time, target);
				mismatches++;
				return;
			end
			want = expected_xlate.pop_front();
			check_field("target_memory", want.target, target);
			check_field("mem_index", want.mem_idx, mem_idx);
			check_field("unmapped_value", want.idle_value, idle_value);
			check_field("irq_line", want.irq, irq);
			check_field("mirror_mode", want.mirror, mirror_out);
		endfunction
	endclass

endpackage

@@ verif/tb_top.sv @@
// Top of the bank switch mapper testbench: clock, reset, request driver,
// response sink with random stalls, directed and random bus traffic.
// Depends on bsm_pkg, bsm_req_if, bsm_rsp_if and bsm_tb_pkg.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import bsm_pkg::*;
	import bsm_tb_pkg::*;

	// variants that decode no registers
	localparam logic [VARIANT_W-1:0] VARIANT_OFF_LO = 3'd0;
	localparam logic [VARIANT_W-1:0] VARIANT_OFF_HI = 3'd7;
	localparam int PHASES = 8;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	bsm_req_if req_if();
	bsm_rsp_if rsp_if();

	mapper_tracker tracker;
	logic [VARIANT_W-1:0] cur_variant = VARIANT_DIRECT;
	bit req_steady = 1'b0;
	bit rsp_steady = 1'b0;

	bank_switch_mapper_irq_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// note accepted requests and check accepted responses
	always @(posedge clk) begin
		if (req_if.valid && req_if.ready)
			tracker.take_request(req_if.req_type, req_if.bus_addr, req_if.write_data);
		if (rsp_if.valid && rsp_if.ready)
			tracker.compare_response(rsp_if.target_memory, rsp_if.mem_index,
				rsp_if.unmapped_value, rsp_if.irq_line, rsp_if.mirror_mode);
	end

	// response sink, random stall per response with steady stretches
	initial begin
		int unsigned stall;
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0) rsp_steady = !rsp_steady;
			stall = rsp_steady ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			@(negedge clk);
			while (rsp_if.valid !== 1'b1) @(negedge clk);
			@(posedge clk);
		end
	end

	// drive one request and hold it until it is taken
	task automatic send_req(logic [REQ_TYPE_W-1:0] kind, logic [ADDR_W-1:0] addr,
			logic [DATA_W-1:0] data);
		int unsigned gap;
		if ($urandom_range(0, 39) == 0) req_steady = !req_steady;
		gap = req_steady ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.req_type <= kind;
		req_if.bus_addr <= addr;
		req_if.write_data <= data;
		@(negedge clk);
		while (req_if.ready !== 1'b1) @(negedge clk);
		@(posedge clk);
	endtask

	// stop requesting and wait for every response to come back
	task automatic wait_idle();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_xlate.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		tracker.configure(index, value);
		@(posedge clk);
	endtask

	task automatic set_config(logic [VARIANT_W-1:0] variant, logic chr_ram,
			logic [PRG_BANK_W-1:0] last_bank);
		wait_idle();
		cfg_write(CFG_BOARD_VARIANT, CFG_DATA_W'(variant));
		cfg_write(CFG_CHR_RAM, CFG_DATA_W'(chr_ram));
		cfg_write(CFG_LAST_PRG, CFG_DATA_W'(last_bank));
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_variant = variant;
	endtask

	// one random bus event, weighted towards decoded register writes
	task automatic random_item();
		int unsigned       pick;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic [3:0]        offset;
		pick = $urandom_range(0, 99);
		addr = ADDR_W'($urandom);
		data = DATA_W'($urandom);
		if (cur_variant == VARIANT_LATCH) base = BASE_LATCH;
		else if (cur_variant == VARIANT_DIRECT) base = BASE_DIRECT;
		else base = $urandom_range(0, 1) ? BASE_LATCH : BASE_DIRECT;
		if (pick < 30) begin
			// counter values kept small so the irq fires often
			offset = 4'($urandom_range(0, REG_CNT_HI));
			if (offset == REG_CNT_HI && $urandom_range(0, 3) != 0)
				data = '0;
			else if (offset == REG_CNT_LO && $urandom_range(0, 3) != 0)
				data = DATA_W'($urandom_range(0, 15));
			send_req(REQ_CPU_WRITE, base + offset, data);
		end else if (pick < 38) begin
			send_req(REQ_CPU_WRITE, addr, data);
		end else if (pick < 55) begin
			send_req(REQ_CPU_READ, addr, data);
		end else if (pick < 72) begin
			if ($urandom_range(0, 4) != 0) addr = ADDR_W'($urandom_range(0, CHR_TOP - 1));
			send_req(REQ_PPU_READ, addr, data);
		end else begin
			send_req(REQ_TICK, addr, data);
		end
	endtask

	initial begin
		logic [VARIANT_W-1:0]  phase_variant [PHASES];
		logic                  phase_chr_ram [PHASES];
		logic [PRG_BANK_W-1:0] phase_last [PHASES];
		int unsigned           phase_items [PHASES];
		phase_variant = '{VARIANT_LATCH, VARIANT_DIRECT, VARIANT_LATCH, VARIANT_DIRECT,
			VARIANT_OFF_HI, VARIANT_LATCH, VARIANT_OFF_LO, VARIANT_DIRECT};
		phase_chr_ram = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
		phase_last = '{4'h0, 4'hF, 4'h7, 4'h3, 4'h9, 4'hF, 4'h0, PRG_BANK_W'($urandom)};
		phase_items = '{150, 150, 150, 150, 50, 150, 50, 150};

		tracker = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		req_if.valid <= 1'b0;
		req_if.req_type <= '0;
		req_if.bus_addr <= '0;
		req_if.write_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// address map edges under the reset configuration
		send_req(REQ_CPU_READ, 16'h0000, '0);
		send_req(REQ_CPU_READ, PRG_RAM_LO - 1'b1, '0);
		send_req(REQ_CPU_READ, PRG_RAM_LO, '0);
		send_req(REQ_CPU_READ, PRG_RAM_HI, '0);
		send_req(REQ_CPU_READ, PRG_ROM_LO, '0);
		send_req(REQ_CPU_READ, PRG_FIXED_LO - 1'b1, '0);
		send_req(REQ_CPU_READ, PRG_FIXED_LO, '0);
		send_req(REQ_CPU_READ, 16'hFFFF, '0);
		send_req(REQ_PPU_READ, 16'h0000, '0);
		send_req(REQ_PPU_READ, CHR_TOP - 1'b1, '0);
		send_req(REQ_PPU_READ, CHR_TOP, '0);
		send_req(REQ_PPU_READ, 16'hFFFF, '0);
		// tick while counting is disabled
		send_req(REQ_TICK, '0, '0);
		// register extremes and undecoded neighbours of the register window
		send_req(REQ_CPU_WRITE, BASE_DIRECT + ADDR_W'(CHR_REGS - 1), 8'hFF);
		send_req(REQ_PPU_READ, CHR_TOP - 1'b1, '0);
		send_req(REQ_CPU_WRITE, BASE_DIRECT + REG_PRG, 8'hFF);
		send_req(REQ_CPU_WRITE, BASE_DIRECT + REG_MIRROR, 8'hFF);
		send_req(REQ_CPU_WRITE, BASE_DIRECT - 1'b1, 8'hFF);
		send_req(REQ_CPU_WRITE, BASE_DIRECT + REG_CNT_HI + 1'b1, 8'hFF);
		// counter runs down to zero and raises the irq, control write clears it
		send_req(REQ_CPU_WRITE, BASE_DIRECT + REG_CNT_LO, 8'h02);
		send_req(REQ_CPU_WRITE, BASE_DIRECT + REG_CNT_HI, 8'h00);
		send_req(REQ_CPU_WRITE, BASE_DIRECT + REG_CTRL, 8'h01);
		repeat (3) send_req(REQ_TICK, '0, '0);
		send_req(REQ_CPU_WRITE, BASE_DIRECT + REG_CTRL, 8'h00);

		// random traffic over several configurations
		for (int p = 0; p < PHASES; p++) begin
			set_config(phase_variant[p], phase_chr_ram[p], phase_last[p]);
			repeat (phase_items[p]) random_item();
		end

		wait_idle();
		repeat (4) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.expected_xlate.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
